// File: rtl/lhf_pkg.sv
// ----------------------------------------------------------------------------
// lhf_pkg
// Shared types and constants of the link health fault classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package lhf_pkg;

   // request kinds
   localparam logic REQ_OBSERVE  = 1'b0;
   localparam logic REQ_DIAGNOSE = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_WINDOW    = 2'd0;
   localparam logic [1:0] CSR_MIN_SAMP  = 2'd1;
   localparam logic [1:0] CSR_POOR_LVL  = 2'd2;
   localparam logic [1:0] CSR_FREQ_LIM  = 2'd3;

   // configuration reset values
   localparam logic [31:0] WINDOW_RESET   = 32'd300000;
   localparam logic [6:0]  MIN_SAMP_RESET = 7'd4;
   localparam logic [7:0]  POOR_LVL_RESET = 8'd30;
   localparam logic [30:0] FREQ_LIM_RESET = 31'd3500;

   // fault classes
   localparam logic [2:0] FAULT_NONE       = 3'd0;
   localparam logic [2:0] FAULT_CONGESTION = 3'd1;
   localparam logic [2:0] FAULT_FREQ       = 3'd2;
   localparam logic [2:0] FAULT_ASYM       = 3'd3;
   localparam logic [2:0] FAULT_BROAD      = 3'd4;
   localparam logic [2:0] FAULT_PEER_LOSS  = 3'd5;

   // distinct peers beyond this never change a decision
   localparam int PEER_CAP = 6;

   localparam int PCT_SCALE = 100;

   typedef struct packed {
      logic        req_type;
      logic [31:0] time_ms;
      logic [31:0] peer_key;
      logic        packet_received;
      logic        ack_received;
      logic [7:0]  channel_health;
      logic signed [31:0] freq_error_hz;
   } lhf_req_type;

   typedef struct packed {
      logic [2:0] fault_class;
      logic [6:0] confidence;
      logic       suppress_background;
      logic       short_backoff;
      logic       radio_reinit;
      logic       rx_focus;
      logic       alternate_transport;
   } lhf_rsp_type;

   typedef struct packed {
      logic [31:0] time_ms;
      logic [31:0] peer;
      logic [1:0]  rx_ack;
      logic [7:0]  health;
      logic [31:0] freq_error;
   } lhf_slot_type;

endpackage

`default_nettype wire

// File: rtl/link_health_fault_classifier_top.sv
// An observe request is written in the cycle it is accepted.
// A diagnose request does one slot memory read per cycle for the scan,
// then works four percentages through one serial divider.
// One diagnose request is worked at a time; observes pass at one per cycle
// only while no diagnose request is being worked.
// Reset clears the used bits, write pointer, configuration, control and counter registers; slot memory is not cleared.
// ----------------------------------------------------------------------------
// link_health_fault_classifier_top
// Ring of recent link observations in a slot memory, scanned on a diagnose
// request to classify the link fault.
// ----------------------------------------------------------------------------
`default_nettype none

module link_health_fault_classifier_top
   import lhf_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire lhf_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output lhf_rsp_type      rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam int CW = $clog2(SAMPLE_DEPTH + 1);
   localparam int NW = CW + 7;
   localparam int SW = $clog2(NW + 1);
   localparam int PW = $clog2(PEER_CAP + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // configuration
   logic [31:0] window_ff;
   logic [6:0]  min_samp_ff;
   logic [7:0]  poor_lvl_ff;
   logic [30:0] freq_lim_ff;

   // slot storage
   lhf_slot_type mem [SAMPLE_DEPTH];
   logic [SAMPLE_DEPTH-1:0] used_ff;
   logic [AW-1:0]   wp_ff;
   lhf_slot_type    rd_data_ff;
   logic            pv_ff;
   logic            pu_ff;

   // control
   logic [1:0]  state_ff, state_in;
   logic [CW-1:0] addr_ff;
   logic [31:0] now_ff;

   // counters
   logic [CW-1:0] n_valid_ff, n_rx_ff, n_ack_ff, n_poor_ff, n_large_ff;
   logic [31:0]   peer_ff [PEER_CAP];
   logic [PW-1:0] n_peer_ff;

   // divider
   logic [1:0]    didx_ff;
   logic [SW-1:0] dstep_ff;
   logic [NW-1:0] num_ff;
   logic [CW-1:0] rem_ff;
   logic [6:0]    pct_ff [4];

   logic          rsp_valid_ff;
   lhf_rsp_type   rsp_data_ff;

   logic          req_acc;
   logic          issue;
   logic          fresh;
   logic          peer_hit;
   logic [31:0]   age;
   logic [31:0]   fe_mag;
   logic [CW-1:0] div_src;
   logic [CW:0]   div_t;
   logic          div_ge;
   logic [CW:0]   div_diff;
   logic [NW-1:0] num_next;
   logic          rsp_free;
   lhf_rsp_type   cls;
   logic [7:0]    rx_p, ack_p, poor_p, frq_p;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign issue     = (state_ff == ST_SCAN) && (addr_ff < CW'(SAMPLE_DEPTH));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= WINDOW_RESET;
         min_samp_ff <= MIN_SAMP_RESET;
         poor_lvl_ff <= POOR_LVL_RESET;
         freq_lim_ff <= FREQ_LIM_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WINDOW:   window_ff   <= csr_wdata;
            CSR_MIN_SAMP: min_samp_ff <= csr_wdata[6:0];
            CSR_POOR_LVL: poor_lvl_ff <= csr_wdata[7:0];
            CSR_FREQ_LIM: freq_lim_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (req_acc && req_data.req_type == REQ_OBSERVE) begin
         mem[wp_ff] <= '{time_ms:    req_data.time_ms,
                         peer:       req_data.peer_key,
                         rx_ack:     {req_data.ack_received, req_data.packet_received},
                         health:     req_data.channel_health,
                         freq_error: req_data.freq_error_hz};
      end
      if (issue) begin
         rd_data_ff <= mem[addr_ff[AW-1:0]];
      end
   end

   // used bits and write pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         wp_ff   <= '0;
      end else if (req_acc && req_data.req_type == REQ_OBSERVE) begin
         used_ff[wp_ff] <= 1'b1;
         wp_ff <= (wp_ff == AW'(SAMPLE_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
      end
   end

   // read pipeline marks
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         pu_ff <= 1'b0;
      end else begin
         pv_ff <= issue;
         pu_ff <= issue && used_ff[addr_ff[AW-1:0]];
      end
   end

   // per-sample tests
   always_comb begin
      age    = now_ff - rd_data_ff.time_ms;
      fresh  = pv_ff && pu_ff && (age <= window_ff);
      fe_mag = rd_data_ff.freq_error[31] ? (32'd0 - rd_data_ff.freq_error)
                                         : rd_data_ff.freq_error;
      peer_hit = 1'b0;
      for (int k = 0; k < PEER_CAP; k++) begin
         if (PW'(k) < n_peer_ff && peer_ff[k] == rd_data_ff.peer) begin
            peer_hit = 1'b1;
         end
      end
   end

   // divider step
   always_comb begin
      unique case (didx_ff)
         2'd0: div_src = n_rx_ff;
         2'd1: div_src = n_ack_ff;
         2'd2: div_src = n_poor_ff;
         2'd3: div_src = n_large_ff;
         default: div_src = n_rx_ff;
      endcase
      div_t    = {rem_ff, num_ff[NW-1]};
      div_ge   = div_t >= {1'b0, n_valid_ff};
      div_diff = div_t - {1'b0, n_valid_ff};
      num_next = {num_ff[NW-2:0], div_ge};
   end

   // sequencer, counters and divider
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
         n_valid_ff <= '0;
         n_rx_ff    <= '0;
         n_ack_ff   <= '0;
         n_poor_ff  <= '0;
         n_large_ff <= '0;
         n_peer_ff  <= '0;
         didx_ff    <= '0;
         dstep_ff   <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_data.req_type == REQ_DIAGNOSE) begin
                  now_ff     <= req_data.time_ms;
                  addr_ff    <= '0;
                  n_valid_ff <= '0;
                  n_rx_ff    <= '0;
                  n_ack_ff   <= '0;
                  n_poor_ff  <= '0;
                  n_large_ff <= '0;
                  n_peer_ff  <= '0;
               end
            end
            ST_SCAN: begin
               if (issue) begin
                  addr_ff <= addr_ff + CW'(1);
               end
               if (fresh) begin
                  n_valid_ff <= n_valid_ff + CW'(1);
                  n_rx_ff    <= n_rx_ff + CW'(rd_data_ff.rx_ack[0]);
                  n_ack_ff   <= n_ack_ff + CW'(rd_data_ff.rx_ack[1]);
                  n_poor_ff  <= n_poor_ff + CW'(rd_data_ff.health < poor_lvl_ff);
                  n_large_ff <= n_large_ff + CW'(fe_mag > {1'b0, freq_lim_ff});
                  if (rd_data_ff.peer != 32'd0 && !peer_hit &&
                      n_peer_ff < PW'(PEER_CAP)) begin
                     peer_ff[n_peer_ff] <= rd_data_ff.peer;
                     n_peer_ff <= n_peer_ff + PW'(1);
                  end
               end
               didx_ff  <= '0;
               dstep_ff <= '0;
            end
            ST_DIV: begin
               if (dstep_ff == '0) begin
                  num_ff   <= NW'(div_src) * NW'(PCT_SCALE);
                  rem_ff   <= '0;
                  dstep_ff <= SW'(1);
               end else begin
                  num_ff <= num_next;
                  rem_ff <= div_ge ? div_diff[CW-1:0] : div_t[CW-1:0];
                  if (dstep_ff == SW'(NW)) begin
                     pct_ff[didx_ff] <= num_next[6:0];
                     didx_ff  <= didx_ff + 2'd1;
                     dstep_ff <= '0;
                  end else begin
                     dstep_ff <= dstep_ff + SW'(1);
                  end
               end
            end
            ST_DONE: ;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc && req_data.req_type == REQ_DIAGNOSE) state_in = ST_SCAN;
         ST_SCAN: if (!issue && !pv_ff) state_in = ST_DIV;
         ST_DIV:  if (dstep_ff == SW'(NW) && didx_ff == 2'd3) state_in = ST_DONE;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // fault classification
   always_comb begin
      rx_p   = {1'b0, pct_ff[0]};
      ack_p  = {1'b0, pct_ff[1]};
      poor_p = {1'b0, pct_ff[2]};
      frq_p  = {1'b0, pct_ff[3]};
      cls = '0;
      if (n_valid_ff != '0 && 8'(n_valid_ff) >= 8'(min_samp_ff)) begin
         priority if (poor_p >= 8'd60) begin
            cls.fault_class = FAULT_CONGESTION;
            cls.confidence  = 7'(((8'd55 + (poor_p >> 1)) > 8'd100) ? 8'd100
                                 : (8'd55 + (poor_p >> 1)));
            cls.suppress_background = 1'b1;
            cls.short_backoff       = 1'b1;
         end else if (frq_p >= 8'd60 && n_peer_ff >= PW'(2)) begin
            cls.fault_class = FAULT_FREQ;
            cls.confidence  = 7'(((8'd50 + (frq_p >> 1)) > 8'd100) ? 8'd100
                                 : (8'd50 + (frq_p >> 1)));
            cls.radio_reinit = 1'b1;
            cls.rx_focus     = 1'b1;
         end else if (8'(n_rx_ff) >= 8'd4 && rx_p >= 8'd60 &&
                      (ack_p + 8'd25) < rx_p) begin
            cls.fault_class = FAULT_ASYM;
            cls.confidence  = 7'(((rx_p - ack_p + 8'd45) > 8'd100) ? 8'd100
                                 : (rx_p - ack_p + 8'd45));
            cls.rx_focus            = 1'b1;
            cls.alternate_transport = 1'b1;
         end else if (n_peer_ff >= PW'(3) && rx_p <= 8'd35 && poor_p < 8'd35) begin
            cls.fault_class = FAULT_BROAD;
            cls.confidence  = 7'(((8'd70 + 8'(n_peer_ff) * 8'd5) > 8'd100) ? 8'd100
                                 : (8'd70 + 8'(n_peer_ff) * 8'd5));
            cls.radio_reinit = 1'b1;
            cls.rx_focus     = 1'b1;
         end else if (n_peer_ff == PW'(1) && rx_p <= 8'd25 && poor_p < 8'd35) begin
            cls.fault_class = FAULT_PEER_LOSS;
            cls.confidence  = 7'd60;
            cls.short_backoff       = 1'b1;
            cls.alternate_transport = 1'b1;
         end else begin
            cls.fault_class = FAULT_NONE;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff <= cls;
      end
   end

endmodule

`default_nettype wire
